// File: rtl/salc_pkg.sv
// shared types and constants of the set-associative cache block
// no dependencies; the interfaces, controller, datapath and top use this package
package salc_pkg;

   localparam int ADDR_BITS  = 30;
   localparam int COUNT_BITS = 32;
   localparam int WAY_OUT_W  = 3;
   localparam int MEM_OUT_W  = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 5;

   localparam int OFFSET_W = 5;
   localparam int INDEX_W  = 4;
   localparam int WAYS_W   = 4;

   // register indexes of the configuration port
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_OFFSET_BITS    = 3'd0,
      CSR_INDEX_BITS     = 3'd1,
      CSR_WAYS_IN_USE    = 3'd2,
      CSR_WRITE_BACK     = 3'd3,
      CSR_WRITE_ALLOCATE = 3'd4
   } csr_index_type;

   typedef enum logic [0:0] {
      ST_IDLE   = 1'b0,
      ST_LOOKUP = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic load;     // take the request word and start the set read
      logic commit;   // resolve the lookup, write the set back, load the result
   } dp_cmd_type;

   typedef struct packed {
      logic out_free; // result register empty or being drained this cycle
   } dp_status_type;

endpackage

// File: rtl/salc_req_if.sv
// request channel: one read or write reference per word
// depends on salc_pkg for the address width
interface salc_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [salc_pkg::ADDR_BITS-1:0] address;

   modport source (output valid, req_type, address, input ready);
   modport sink (input valid, req_type, address, output ready);
endinterface

// File: rtl/salc_rsp_if.sv
// response channel: one lookup result per request word
// depends on salc_pkg for field widths
interface salc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            hit;
   logic [salc_pkg::WAY_OUT_W-1:0]  way_used;
   logic                            filled;
   logic                            victim_writeback;
   logic [salc_pkg::MEM_OUT_W-1:0]  memory_accesses;
   logic [salc_pkg::COUNT_BITS-1:0] hit_total;
   logic [salc_pkg::COUNT_BITS-1:0] miss_total;
   logic [salc_pkg::COUNT_BITS-1:0] memory_total;

   modport source (output valid, hit, way_used, filled, victim_writeback, memory_accesses,
                   hit_total, miss_total, memory_total, input ready);
   modport sink (input valid, hit, way_used, filled, victim_writeback, memory_accesses,
                 hit_total, miss_total, memory_total, output ready);
endinterface

// File: rtl/salc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic                                 re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/salc_ctrl.sv
// controller: sequences accept, set read and commit of one reference
// depends on salc_pkg for state, command and status types
module salc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  salc_pkg::dp_status_type status,
   output logic                    req_ready,
   output salc_pkg::dp_cmd_type    cmd
);
   import salc_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free;
            if (req_valid && status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

// File: rtl/salc_dp.sv
// datapath: config registers, address split, set ram, lookup, lru update,
// counters and result register; depends on salc_pkg, salc_ram, salc_rsp_if
module salc_dp #(
   parameter int MAX_SETS = 256,
   parameter int MAX_WAYS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [salc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [salc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_type,
   input  logic [salc_pkg::ADDR_BITS-1:0]      req_address,
   input  salc_pkg::dp_cmd_type                cmd,
   output salc_pkg::dp_status_type             status,
   salc_rsp_if.source                          rsp
);
   import salc_pkg::*;

   localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int MAX_IB = $clog2(MAX_SETS + 1) - 1;
   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int REC_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int ROW_W  = MAX_WAYS * (2 + REC_W + ADDR_BITS);
   localparam int DIRTY_LO = MAX_WAYS;
   localparam int REC_LO   = 2 * MAX_WAYS;
   localparam int TAG_LO   = 2 * MAX_WAYS + MAX_WAYS * REC_W;
   localparam logic [REC_W-1:0] REC_MAX = REC_W'(MAX_WAYS - 1);

   // configuration
   logic [OFFSET_W-1:0] offset_bits_ff;
   logic [INDEX_W-1:0]  index_bits_ff;
   logic [WAYS_W-1:0]   ways_ff;
   logic                wback_ff;
   logic                walloc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= OFFSET_W'(2);
         index_bits_ff  <= '0;
         ways_ff        <= WAYS_W'(1);
         wback_ff       <= 1'b0;
         walloc_ff      <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_OFFSET_BITS:    offset_bits_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_INDEX_BITS:     index_bits_ff  <= csr_wdata[INDEX_W-1:0];
            CSR_WAYS_IN_USE:    ways_ff        <= csr_wdata[WAYS_W-1:0];
            CSR_WRITE_BACK:     wback_ff       <= csr_wdata[0];
            CSR_WRITE_ALLOCATE: walloc_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // address split
   logic [INDEX_W-1:0]   ib_eff;
   logic [ADDR_BITS-1:0] shifted;
   logic [ADDR_BITS-1:0] set_full;
   logic [SET_W-1:0]     set_now;
   logic [ADDR_BITS-1:0] tag_now;

   always_comb begin
      ib_eff   = (index_bits_ff > INDEX_W'(MAX_IB)) ? INDEX_W'(MAX_IB) : index_bits_ff;
      shifted  = req_address >> offset_bits_ff;
      set_full = shifted & ~({ADDR_BITS{1'b1}} << ib_eff);
      set_now  = set_full[SET_W-1:0];
      tag_now  = req_address >> ({1'b0, offset_bits_ff} + {2'b00, ib_eff});
   end

   logic [SET_W-1:0]     set_ff;
   logic [ADDR_BITS-1:0] tag_ff;
   logic                 wr_ff;
   logic                 row_ok_ff;
   logic [MAX_SETS-1:0]  row_written_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         set_ff    <= set_now;
         tag_ff    <= tag_now;
         wr_ff     <= req_type;
         row_ok_ff <= row_written_ff[set_now];
      end
   end

   // a row never written reads as all ways invalid with zero recency
   always_ff @(posedge clock) begin
      if (reset) begin
         row_written_ff <= '0;
      end else if (cmd.commit) begin
         row_written_ff[set_ff] <= 1'b1;
      end
   end

   logic [ROW_W-1:0] rd_row;
   logic [ROW_W-1:0] wr_row;

   salc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_set_ram (
      .clock (clock),
      .we    (cmd.commit),
      .waddr (set_ff),
      .wdata (wr_row),
      .re    (cmd.load),
      .raddr (set_now),
      .rdata (rd_row)
   );

   // lookup and update
   logic [4:0]           nways;
   logic [MAX_WAYS-1:0]  act, v, d, match, empty;
   logic [REC_W-1:0]     r [MAX_WAYS];
   logic [ADDR_BITS-1:0] t [MAX_WAYS];
   logic                 hit;
   logic [WAY_W-1:0]     hit_way, empty_way, lru_way, way;
   logic [REC_W-1:0]     oldest, prev;
   logic                 found, fill, vdirty, touch;
   logic [MEM_OUT_W-1:0] mem;

   always_comb begin
      nways = {1'b0, ways_ff};
      if (nways == 5'd0) begin
         nways = 5'd1;
      end
      if (nways > 5'(MAX_WAYS)) begin
         nways = 5'(MAX_WAYS);
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
         act[i]   = (5'(i) < nways);
         v[i]     = row_ok_ff & rd_row[i];
         d[i]     = row_ok_ff & rd_row[DIRTY_LO + i];
         r[i]     = row_ok_ff ? rd_row[REC_LO + i*REC_W +: REC_W] : '0;
         t[i]     = rd_row[TAG_LO + i*ADDR_BITS +: ADDR_BITS];
         match[i] = act[i] & v[i] & (t[i] == tag_ff);
         empty[i] = act[i] & ~v[i];
      end
      hit       = |match;
      found     = |empty;
      hit_way   = '0;
      empty_way = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (match[i]) hit_way = WAY_W'(i);
         if (empty[i]) empty_way = WAY_W'(i);
      end
      oldest  = r[0];
      lru_way = '0;
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (act[i] && r[i] > oldest) begin
            oldest  = r[i];
            lru_way = WAY_W'(i);
         end
      end
      fill   = !hit && (!wr_ff || walloc_ff);
      vdirty = fill && !found && d[lru_way];
      way    = hit ? hit_way : (fill ? (found ? empty_way : lru_way) : '0);
      touch  = hit || fill;
      prev   = v[way] ? r[way] : REC_MAX;
      if (hit) begin
         mem = (wr_ff && !wback_ff) ? MEM_OUT_W'(1) : MEM_OUT_W'(0);
      end else begin
         mem = vdirty ? MEM_OUT_W'(2) : MEM_OUT_W'(1);
      end
   end

   always_comb begin
      wr_row = rd_row;
      for (int i = 0; i < MAX_WAYS; i++) begin
         wr_row[i]            = v[i];
         wr_row[DIRTY_LO + i] = d[i];
         wr_row[REC_LO + i*REC_W +: REC_W] = r[i];
         if (touch) begin
            if (WAY_W'(i) == way) begin
               wr_row[REC_LO + i*REC_W +: REC_W] = '0;
            end else if (act[i] && v[i] && r[i] <= prev && r[i] < REC_MAX) begin
               wr_row[REC_LO + i*REC_W +: REC_W] = r[i] + REC_W'(1);
            end
         end
         if (WAY_W'(i) == way) begin
            if (hit && wr_ff && wback_ff) begin
               wr_row[DIRTY_LO + i] = 1'b1;
            end
            if (fill) begin
               wr_row[i]            = 1'b1;
               wr_row[DIRTY_LO + i] = wr_ff && wback_ff;
               wr_row[TAG_LO + i*ADDR_BITS +: ADDR_BITS] = tag_ff;
            end
         end
      end
   end

   // counters and result register
   logic [COUNT_BITS-1:0] hit_cnt_ff, miss_cnt_ff, mem_cnt_ff;
   logic [COUNT_BITS-1:0] hit_cnt_in, miss_cnt_in, mem_cnt_in;
   logic                  out_valid_ff;
   logic                  hit_ff, filled_ff, vwb_ff;
   logic [WAY_OUT_W-1:0]  way_ff;
   logic [MEM_OUT_W-1:0]  mem_ff;

   assign hit_cnt_in  = hit_cnt_ff + COUNT_BITS'(hit);
   assign miss_cnt_in = miss_cnt_ff + COUNT_BITS'(!hit);
   assign mem_cnt_in  = mem_cnt_ff + COUNT_BITS'(mem);

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         mem_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            hit_cnt_ff   <= hit_cnt_in;
            miss_cnt_ff  <= miss_cnt_in;
            mem_cnt_ff   <= mem_cnt_in;
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hit_ff    <= hit;
         way_ff    <= WAY_OUT_W'(way);
         filled_ff <= fill;
         vwb_ff    <= vdirty;
         mem_ff    <= mem;
      end
   end

   assign status.out_free      = !out_valid_ff || rsp.ready;
   assign rsp.valid            = out_valid_ff;
   assign rsp.hit              = hit_ff;
   assign rsp.way_used         = way_ff;
   assign rsp.filled           = filled_ff;
   assign rsp.victim_writeback = vwb_ff;
   assign rsp.memory_accesses  = mem_ff;
   assign rsp.hit_total        = hit_cnt_ff;
   assign rsp.miss_total       = miss_cnt_ff;
   assign rsp.memory_total     = mem_cnt_ff;

   a_commit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !out_valid_ff)
      else $error("result register overwritten");

   a_one_count_per_item: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (hit_cnt_ff + miss_cnt_ff) == ($past(hit_cnt_ff) + $past(miss_cnt_ff)
                                                  + COUNT_BITS'(1)))
      else $error("hit and miss counts out of step");

   a_writeback_needs_fill: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && vdirty |-> fill && !hit && mem == MEM_OUT_W'(2))
      else $error("victim write-back without a fill");

   a_load_then_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.commit && !cmd.load)
      else $error("lookup not committed after set read");
endmodule

// File: rtl/set_assoc_cache_lru_write_policy.sv
// Set-associative cache model, LRU replacement, write-back/write-through and
// write-allocate selectable. Each request word (req_type, address) is one read
// or write reference; each produces exactly one response word with hit, way,
// fill and write-back flags, memory references caused, and running hit, miss
// and memory-reference totals that wrap.
// Configuration is a plain write port (csr_we, csr_addr, csr_wdata); the user must
// write it only while no reference is in flight, the block does not enforce this.
// A request accepted at one edge is read from the set ram on that edge and its
// response is registered on the next edge. The registered set ram read followed
// by the write of the whole updated set row means no new reference is accepted
// until the last one has committed its row.
// A new request is accepted while a finished response still waits, as long
// as that response is being taken in the same cycle; a stalled response
// holds, and requests wait until the response register frees.
// Reset (synchronous) empties the cache at once through a per-set row-valid
// flag, zeroes the totals and loads the default configuration; no sweep.
// Depends on salc_pkg, salc_req_if, salc_rsp_if, salc_ctrl, salc_dp.
module set_assoc_cache_lru_write_policy #(
   parameter int MAX_SETS = 256,
   parameter int MAX_WAYS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [salc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [salc_pkg::CSR_DATA_W-1:0] csr_wdata,
   salc_req_if.sink                        req_chan,
   salc_rsp_if.source                      rsp_chan
);
   import salc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   salc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (status),
      .req_ready (req_chan.ready),
      .cmd       (cmd)
   );

   salc_dp #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_type    (req_chan.req_type),
      .req_address (req_chan.address),
      .cmd         (cmd),
      .status      (status),
      .rsp         (rsp_chan)
   );
endmodule
